@@ hw/rtl/tdc_pkg.sv @@
`timescale 1ns / 1ps

package tdc_pkg;

    // Field widths of the event and drive words.
    localparam int OP_W    = 2;
    localparam int TIME_W  = 32;
    localparam int SEG_W   = 7;
    localparam int CNT_W   = 7;
    localparam int WIN_W   = 16;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // Register indexes, taken from paddr[APB_AW-1:2].
    localparam logic REG_WINDOW = 1'b0;

    // Reset value of the double-press window in milliseconds.
    localparam logic [WIN_W-1:0] WINDOW_RST = 16'd1000;

    // Default count modulus.
    localparam int COUNT_MODULUS_DEF = 100;

    // Event codes. The fourth code carries no meaning and changes nothing.
    typedef enum logic [OP_W-1:0] {
        OP_SECOND  = 2'd0,
        OP_REFRESH = 2'd1,
        OP_PRESS   = 2'd2
    } t_op;

    // Drive state returned for every event.
    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic             tens_cathode;
        logic [CNT_W-1:0] count_value;
        logic             paused;
    } t_drive;

    // Seven-segment font, bit 0 is segment a through bit 6 is segment g.
    function automatic logic [SEG_W-1:0] seg_font(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 7'b0111111;
            4'd1:    seg = 7'b0000110;
            4'd2:    seg = 7'b1011011;
            4'd3:    seg = 7'b1001111;
            4'd4:    seg = 7'b1100110;
            4'd5:    seg = 7'b1101101;
            4'd6:    seg = 7'b1111101;
            4'd7:    seg = 7'b0000111;
            4'd8:    seg = 7'b1111111;
            4'd9:    seg = 7'b1101111;
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

@@ hw/rtl/tdc_if.sv @@
`timescale 1ns / 1ps

// Event channel: one word per event.
interface tdc_in_if
    import tdc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] press_time_ms;

    modport source (output valid, output op, output press_time_ms, input ready);
    modport sink   (input valid, input op, input press_time_ms, output ready);
endinterface

// Drive channel: one word per event.
interface tdc_out_if
    import tdc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic             tens_cathode;
    logic [CNT_W-1:0] count_value;
    logic             paused;

    modport source (output valid, output segments, output tens_cathode,
                    output count_value, output paused, input ready);
    modport sink   (input valid, input segments, input tens_cathode,
                    input count_value, input paused, output ready);
endinterface

@@ hw/rtl/tdc_cfg.sv @@
`timescale 1ns / 1ps

module tdc_cfg
    import tdc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [WIN_W-1:0]  o_window
);

    logic [WIN_W-1:0] r_window;
    logic [WIN_W-1:0] n_window;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1];
    assign wr_en   = psel && penable && pwrite && pready;

    // Window register takes the low half of the write data.
    always_comb begin
        n_window = r_window;
        if (wr_en && (reg_idx == REG_WINDOW)) begin
            n_window = pwdata[WIN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
        end else begin
            r_window <= n_window;
        end
    end

    // Read back; addresses past the register list read as zero.
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_WINDOW) begin
            prdata = {{(APB_DW-WIN_W){1'b0}}, r_window};
        end
    end

    assign o_window = r_window;

endmodule

@@ hw/rtl/tdc_core.sv @@
`timescale 1ns / 1ps

module tdc_core
    import tdc_pkg::*;
#(
    parameter int COUNT_MODULUS = COUNT_MODULUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [OP_W-1:0]   i_op,
    input  logic [TIME_W-1:0] i_press_time_ms,
    input  logic [WIN_W-1:0]  i_window,
    output t_drive            o_drive
);

    localparam logic [CNT_W:0] MOD = (CNT_W+1)'(COUNT_MODULUS);

    logic [CNT_W-1:0]  r_count,      n_count;
    logic              r_paused,     n_paused;
    logic              r_show_tens,  n_show_tens;
    logic [TIME_W-1:0] r_last_press, n_last_press;
    logic [SEG_W-1:0]  r_seg,        n_seg;
    logic              r_cathode,    n_cathode;

    logic [CNT_W:0]    inc;
    logic [TIME_W-1:0] gap;
    logic              double_press;
    logic [13:0]       tens_prod;
    logic [3:0]        tens;
    logic [CNT_W-1:0]  tens_x10;
    logic [CNT_W-1:0]  ones_full;
    logic [3:0]        ones;

    // Digit split: tens by reciprocal multiply, exact for counts below 100.
    assign tens_prod = 14'(r_count) * 14'd103;
    assign tens      = tens_prod[13:10];
    assign tens_x10  = CNT_W'({tens, 3'b000}) + CNT_W'({tens, 1'b0});
    assign ones_full = r_count - tens_x10;
    assign ones      = ones_full[3:0];

    assign inc          = {1'b0, r_count} + 1'b1;
    assign gap          = i_press_time_ms - r_last_press;
    assign double_press = gap < {{(TIME_W-WIN_W){1'b0}}, i_window};

    // Next state for the event in the input register.
    always_comb begin
        n_count      = r_count;
        n_paused     = r_paused;
        n_show_tens  = r_show_tens;
        n_last_press = r_last_press;
        n_seg        = r_seg;
        n_cathode    = r_cathode;
        if (i_fire) begin
            case (i_op)
                OP_SECOND: begin
                    if (!r_paused) begin
                        n_count = (inc >= MOD) ? '0 : inc[CNT_W-1:0];
                    end
                end
                OP_REFRESH: begin
                    if (r_show_tens) begin
                        n_cathode = 1'b1;
                        n_seg     = (tens == 4'd0) ? '0 : seg_font(tens);
                    end else begin
                        n_cathode = 1'b0;
                        n_seg     = seg_font(ones);
                    end
                    n_show_tens = !r_show_tens;
                end
                OP_PRESS: begin
                    if (double_press) begin
                        n_count  = '0;
                        n_paused = 1'b0;
                    end else begin
                        n_paused = !r_paused;
                    end
                    n_last_press = i_press_time_ms;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_paused     <= 1'b0;
            r_show_tens  <= 1'b1;
            r_last_press <= '0;
            r_seg        <= '0;
            r_cathode    <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_paused     <= n_paused;
            r_show_tens  <= n_show_tens;
            r_last_press <= n_last_press;
            r_seg        <= n_seg;
            r_cathode    <= n_cathode;
        end
    end

    // The result word is the state after the event.
    assign o_drive.segments     = n_seg;
    assign o_drive.tens_cathode = n_cathode;
    assign o_drive.count_value  = n_count;
    assign o_drive.paused       = n_paused;

    // The count never reaches the modulus.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_count} < MOD)
        else $error("count out of range");

    // Each refresh swaps the digit position.
    a_refresh_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_REFRESH) |=> (r_show_tens != $past(r_show_tens)))
        else $error("refresh did not swap digit");

    // The latched cathode follows the position that was due.
    a_cathode_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_REFRESH) |=> (r_cathode == $past(r_show_tens)))
        else $error("cathode does not match digit position");

    // A paused counter ignores second ticks.
    a_paused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_op == OP_SECOND && r_paused) |=> $stable(r_count))
        else $error("count moved while paused");

endmodule

@@ hw/rtl/two_digit_counter_with_mux_display_unit.sv @@
`timescale 1ns / 1ps

// Two-digit counter with a multiplexed seven-segment display drive.
// Event words enter on i_in: op 0 is a one-second tick, op 1 a display
// refresh, op 2 a button press with its millisecond timestamp. Every
// event returns one drive word on o_out: latched segments and digit
// select, the count, and the pause flag, all as they stand after it.
// The double-press window is set over the APB port at byte address 0.
// An event is registered at the input, updated against the block state
// in one pass of short logic, and the drive word is registered at the
// output when the output register is free or being read.
// One event is accepted every cycle while the receiver does not stall;
// the state update made for one event is what the next event sees.
// When the receiver stalls, the drive word holds, the input register
// keeps one further event, and i_in.ready falls once both are full.
// Reset clears the count, starts counting, puts the tens digit first,
// blanks the segments and sets the window to 1000 ms.
module two_digit_counter_with_mux_display_unit
    import tdc_pkg::*;
#(
    parameter int COUNT_MODULUS = COUNT_MODULUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tdc_in_if.sink            i_in,
    tdc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic              r_in_valid,  n_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [TIME_W-1:0] r_time;
    logic              r_out_valid, n_out_valid;
    t_drive            r_out;

    logic              in_fire;
    logic              proc_fire;
    logic [WIN_W-1:0]  window;
    t_drive            drive;

    // Configuration registers.
    tdc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_window(window)
    );

    // Counter and display state.
    tdc_core #(
        .COUNT_MODULUS(COUNT_MODULUS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (proc_fire),
        .i_op           (r_op),
        .i_press_time_ms(r_time),
        .i_window       (window),
        .o_drive        (drive)
    );

    // Handshake: the input word moves on when the output slot frees up.
    assign proc_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || proc_fire;
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = in_fire ? 1'b1 : (proc_fire ? 1'b0 : r_in_valid);
        n_out_valid = proc_fire ? 1'b1 : (o_out.ready ? 1'b0 : r_out_valid);
    end

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= i_in.op;
            r_time <= i_in.press_time_ms;
        end
        if (proc_fire) begin
            r_out <= drive;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.segments     = r_out.segments;
    assign o_out.tens_cathode = r_out.tens_cathode;
    assign o_out.count_value  = r_out.count_value;
    assign o_out.paused       = r_out.paused;

    // An event is only processed when its word can be placed.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !proc_fire)
        else $error("drive word overwritten while stalled");

    // A processed event always yields a drive word next cycle.
    a_proc_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire |=> r_out_valid)
        else $error("processed event produced no word");

    // The input register is never loaded while it holds an unprocessed word.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc_fire) |-> !in_fire)
        else $error("input word overwritten");

endmodule
